[src/hrd_pkg.sv]
package hrd_pkg;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_RECORD     = 3'd1,
    KIND_MISSING    = 3'd2,
    KIND_UNEXPECTED = 3'd3,
    KIND_BADCHAR    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_D1   = 4'b0010,
    PH_D2   = 4'b0100,
    PH_D3   = 4'b1000
  } phase_t;

  typedef enum logic [0:0] {
    REG_START = 1'b0,
    REG_STEP  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

  localparam logic [15:0] START_RESET = 16'd495;
  localparam logic [7:0]  STEP_RESET  = 8'd5;
  localparam logic [7:0]  MARK_LIMIT  = 8'd64;
  localparam int          SUM_W       = 20;
  localparam int          FOUT_W      = 24;

  function automatic nibble_t nibble_of(input logic [7:0] c);
    nibble_t n;
    n.ok  = 1'b0;
    n.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.ok  = 1'b1;
      n.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n.ok  = 1'b1;
      n.val = 4'(c - 8'h37);
    end
    return n;
  endfunction

endpackage

[src/hex_record_deframer_top.sv]
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_ready   | in_high_char[7:0], in_low_char[7:0]
// out      | out_valid / out_ready | out_kind[2:0], out_frequency_quarters[23:0],
//          |                       | out_failure_count[19:0]
// cfg      | cfg_valid / cfg_ready | cfg_index[0:0], cfg_data[15:0]
//
// one item per cycle unless out stalls; out valid rises via input then result reg
// rate set by the single frame state update between input and result registers
// synchronous active-low reset; frequency returns to START_RESET on reset
// out stall holds the result register; one more item parks in the input register
// cfg_ready is always high; a start write also reloads the frequency
module hex_record_deframer_top #(
  parameter int FREQ_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_high_char,
  input  logic [7:0]           in_low_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hrd_pkg::kind_t       out_kind,
  output logic [23:0]          out_frequency_quarters,
  output logic [19:0]          out_failure_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import hrd_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [7:0]            s1_hi_r, s1_lo_r;
  logic                  out_valid_r, out_valid_nxt;
  kind_t                 out_kind_r, kind_nxt;
  logic [FOUT_W-1:0]     out_freq_r, fout_nxt;
  logic [SUM_W-1:0]      out_count_r, count_nxt;
  phase_t                phase_r, phase_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [FREQ_WIDTH-1:0] freq_r, freq_nxt, freq_inc;
  logic [7:0]            step_r;
  logic                  adv, in_fire, cfg_fire, work;
  nibble_t               nh, nl;
  logic [7:0]            dbyte, dval;
  logic [SUM_W-1:0]      dext;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv || !s1_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign work     = adv && s1_valid_r;
  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  assign nh    = nibble_of(s1_hi_r);
  assign nl    = nibble_of(s1_lo_r);
  assign dbyte = {nh.val, nl.val};
  assign dval  = dbyte - MARK_LIMIT;
  assign dext  = SUM_W'(dval);
  assign freq_inc = freq_r + FREQ_WIDTH'(step_r);

  always_comb begin
    kind_nxt  = KIND_NONE;
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    freq_nxt  = freq_r;
    fout_nxt  = FOUT_W'(freq_r);
    count_nxt = '0;
    if (!nh.ok || !nl.ok) begin
      kind_nxt = KIND_BADCHAR;
    end else if (dbyte < MARK_LIMIT) begin
      freq_nxt  = freq_inc;
      phase_nxt = PH_D1;
      sum_nxt   = '0;
      if (phase_r != PH_IDLE) begin
        kind_nxt = KIND_MISSING;
      end else begin
        fout_nxt = FOUT_W'(freq_inc);
      end
    end else begin
      unique case (phase_r)
        PH_D1: begin
          sum_nxt   = sum_r + dext;
          phase_nxt = PH_D2;
        end
        PH_D2: begin
          sum_nxt   = sum_r + (dext << 6);
          phase_nxt = PH_D3;
        end
        PH_D3: begin
          sum_nxt   = sum_r + (dext << 12);
          count_nxt = sum_nxt;
          kind_nxt  = KIND_RECORD;
          phase_nxt = PH_IDLE;
        end
        default: begin
          kind_nxt = KIND_UNEXPECTED;
          sum_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_hi_r <= in_high_char;
      s1_lo_r <= in_low_char;
    end
    if (work) begin
      out_kind_r  <= kind_nxt;
      out_freq_r  <= fout_nxt;
      out_count_r <= count_nxt;
    end
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      sum_r       <= '0;
      step_r      <= STEP_RESET;
      freq_r      <= FREQ_WIDTH'(START_RESET);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        unique case (reg_idx_t'(cfg_index))
          REG_START: begin
            freq_r  <= FREQ_WIDTH'(cfg_data);
          end
          REG_STEP: step_r <= cfg_data[7:0];
          default: ;
        endcase
      end else if (work) begin
        freq_r <= freq_nxt;
      end
      if (work) begin
        phase_r <= phase_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_kind               = out_kind_r;
  assign out_frequency_quarters = out_freq_r;
  assign out_failure_count      = out_count_r;

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase register not one-hot");

  a_count_only_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_RECORD |-> out_failure_count == '0)
    else $error("failure count set on a non-record item");

  a_record_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    work && kind_nxt == KIND_RECORD |=> phase_r == PH_IDLE)
    else $error("frame not closed after record");

  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free pipeline slot");

  a_marker_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
    work && (kind_nxt == KIND_MISSING) |=> phase_r == PH_D1 && sum_r == '0)
    else $error("missing-data marker did not open a new frame");

endmodule

[tb/hex_record_deframer_top_test.sv]
module hex_record_deframer_top_test;
  import hrd_pkg::*;

  localparam int STUCK_LIMIT = 1000;

  typedef struct {
    kind_t       kind;
    logic [23:0] freq;
    logic [19:0] count;
  } deframe_rec_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [7:0]     in_high_char = 8'h30;
  logic [7:0]     in_low_char = 8'h30;
  logic           out_valid;
  logic           out_ready = 1'b0;
  kind_t          out_kind;
  logic [23:0]    out_frequency_quarters;
  logic [19:0]    out_failure_count;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [0:0]     cfg_index = 1'b0;
  logic [15:0]    cfg_data = 16'd0;

  // deframer state as the block should hold it
  logic [7:0]     mdl_step = STEP_RESET;
  logic [23:0]    mdl_freq = 24'(START_RESET);
  logic [19:0]    mdl_sum = '0;
  int unsigned    mdl_phase = 0;

  deframe_rec_t   deframed_q[$];
  int             errors = 0;
  int             stuck = 0;
  int             hold_cycles = 0;
  bit             idle_on = 1'b1;

  hex_record_deframer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_high_char(in_high_char),
    .in_low_char(in_low_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_frequency_quarters(out_frequency_quarters),
    .out_failure_count(out_failure_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic hex_value(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  function automatic deframe_rec_t deframe(input logic [7:0] hi, input logic [7:0] lo);
    deframe_rec_t r;
    logic [3:0]   nh;
    logic [3:0]   nl;
    logic         ok_h;
    logic         ok_l;
    logic [7:0]   b;
    logic [19:0]  d;
    r.kind  = KIND_NONE;
    r.count = '0;
    r.freq  = mdl_freq;
    ok_h = hex_value(hi, nh);
    ok_l = hex_value(lo, nl);
    if (!(ok_h && ok_l)) begin
      r.kind = KIND_BADCHAR;
      return r;
    end
    b = {nh, nl};
    if (b < MARK_LIMIT) begin
      if (mdl_phase != 0) r.kind = KIND_MISSING;
      mdl_freq = mdl_freq + 24'(mdl_step);
      if (r.kind != KIND_MISSING) r.freq = mdl_freq;
      mdl_phase = 1;
      mdl_sum = '0;
    end else begin
      d = 20'(b - MARK_LIMIT);
      case (mdl_phase)
        1: begin
          mdl_sum = mdl_sum + d;
          mdl_phase = 2;
        end
        2: begin
          mdl_sum = mdl_sum + (d << 6);
          mdl_phase = 3;
        end
        3: begin
          mdl_sum = mdl_sum + (d << 12);
          r.kind = KIND_RECORD;
          r.count = mdl_sum;
          mdl_phase = 0;
        end
        default: begin
          r.kind = KIND_UNEXPECTED;
          mdl_sum = '0;
        end
      endcase
      r.freq = mdl_freq;
    end
    return r;
  endfunction

  task automatic send_item(input logic [7:0] hi, input logic [7:0] lo);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_high_char <= hi;
    in_low_char <= lo;
    do @(posedge clk); while (!in_ready);
    deframed_q.push_back(deframe(hi, lo));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(hex_ascii(b[7:4]), hex_ascii(b[3:0]));
  endtask

  task automatic send_frame(input logic [7:0] mark, input logic [7:0] d1,
                            input logic [7:0] d2, input logic [7:0] d3);
    send_byte(mark);
    send_byte(d1);
    send_byte(d2);
    send_byte(d3);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_START) begin
      mdl_freq = 24'(data);
    end else begin
      mdl_step = data[7:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_frame_mix();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send_frame(8'($urandom_range(0, 63)), 8'($urandom_range(64, 255)),
                 8'($urandom_range(64, 255)), 8'($urandom_range(64, 255)));
    end else if (r < 80) begin
      // frame cut short: a marker and at most two data bytes
      send_byte(8'($urandom_range(0, 63)));
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(64, 255)));
    end else if (r < 88) begin
      send_byte(8'($urandom_range(64, 255)));
    end else if (r < 95) begin
      send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 63)));
      send_byte(8'($urandom_range(64, 255)));
      send_item(8'($urandom_range(0, 255)), "G");
      send_byte(8'($urandom_range(64, 255)));
      send_byte(8'($urandom_range(64, 255)));
    end
  endtask

  task automatic test_bad_chars_and_framing();
    send_item("G", "0");
    send_item("0", 8'h2F);
    send_item(":", "A");
    send_item("@", "0");
    send_item("F", "a");
    send_item(8'hFF, 8'h00);
    send_byte(8'h40);
    send_byte(8'hFF);
    send_frame(8'h00, 8'h40, 8'h40, 8'h40);
    send_frame(8'h3F, 8'hFF, 8'hFF, 8'hFF);
    send_byte(8'h01);
    send_byte(8'h41);
    send_byte(8'h02);
    send_byte(8'h80);
    send_item("Z", "Z");
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h10);
    send_byte(8'h20);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_START, 16'h0000);
    write_reg(REG_STEP, 16'hFF00);
    repeat (6) random_frame_mix();
    drain();
    write_reg(REG_START, 16'hFFFF);
    write_reg(REG_STEP, 16'hFFFF);
    repeat (6) random_frame_mix();
    drain();
    write_reg(REG_STEP, 16'h0001);
    repeat (4) random_frame_mix();
    drain();
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    hold_cycles = 80;
    repeat (8) send_frame(8'($urandom_range(0, 63)), 8'($urandom_range(64, 255)),
                          8'($urandom_range(64, 255)), 8'($urandom_range(64, 255)));
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int rounds);
    for (int i = 0; i < rounds; i++) begin
      random_frame_mix();
      if (i % 30 == 29) begin
        drain();
        write_reg(REG_START, 16'($urandom_range(0, 65535)));
        write_reg(REG_STEP, 16'($urandom_range(0, 65535)));
      end
    end
    drain();
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    deframe_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: result with nothing pending, kind %0d", $time, out_kind);
        errors++;
      end else begin
        want = deframed_q.pop_front();
        if (out_kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_kind);
          errors++;
        end
        if (out_frequency_quarters !== want.freq) begin
          $display("%0t: frequency expected %0d actual %0d", $time, want.freq,
                   out_frequency_quarters);
          errors++;
        end
        if (out_failure_count !== want.count) begin
          $display("%0t: failure count expected %0d actual %0d", $time, want.count,
                   out_failure_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("%0t: no progress, %0d results pending", $time, deframed_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_bad_chars_and_framing();
    test_register_extremes();
    test_output_stall();
    test_random_traffic(80);
    idle_on = 1'b0;
    test_random_traffic(20);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/hrd_pkg.sv
src/hex_record_deframer_top.sv
tb/hex_record_deframer_top_test.sv
